@@ hdl/origin_shift_maze_grid_top_macros.svh @@
// Assertion macros for the origin-shift maze grid.
// Used by origin_shift_maze_grid_top; expects clk and arst_n in scope.
`ifndef ORIGIN_SHIFT_MAZE_GRID_TOP_MACROS_SVH
`define ORIGIN_SHIFT_MAZE_GRID_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OSMG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OSMG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/osmg_pkg.sv @@
// Package for the origin-shift maze grid: sizes, operation, direction,
// cell and sequencer state codes. No dependencies.
package osmg_pkg;

	// Default grid capacity.
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	// Fixed field widths.
	localparam int SIZE_W    = 7;
	localparam int COORD_W   = 6;
	localparam int OP_W      = 2;
	localparam int DIR_W     = 2;
	localparam int CELL_W    = 3;
	localparam int CFG_IDX_W = 1;

	// Grid size registers.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
	localparam int MIN_SIZE = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_SHIFT = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef enum logic [CELL_W-1:0] {
		CELL_RIGHT  = 3'd0,
		CELL_DOWN   = 3'd1,
		CELL_LEFT   = 3'd2,
		CELL_UP     = 3'd3,
		CELL_ORIGIN = 3'd4
	} cell_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_SHIFT2,
		ST_READW,
		ST_RESP
	} state_t;

endpackage

@@ hdl/origin_shift_maze_grid_top.sv @@
// Origin-shift maze grid: cell memory, origin registers and sequencer.
// Depends on osmg_pkg and origin_shift_maze_grid_top_macros.svh.
//
// The block holds a maze grid in one single-port memory and handles one request at a
// time. A read makes one memory read; a legal shift makes two memory writes, one for
// the old origin cell and one for the new; a rejected shift or read touches no memory;
// an initialize sweeps the grid, writing one cell per cycle through the single memory
// port. After reset the same sweep lays down the start maze for the reset size, and no
// request is taken until it ends; configuration writes are taken at any time. A result
// waits in an output register, so the next request can start while it is held.

`include "origin_shift_maze_grid_top_macros.svh"

module origin_shift_maze_grid_top
	import osmg_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	// Requests.
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [DIR_W-1:0]     direction,
	input  logic [COORD_W-1:0]   cell_x,
	input  logic [COORD_W-1:0]   cell_y,
	// Results.
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 accepted,
	output logic [COORD_W-1:0]   origin_col,
	output logic [COORD_W-1:0]   origin_row,
	output logic [CELL_W-1:0]    cell_value
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int HB    = $clog2(MAX_HEIGHT + 1);
	localparam int SW0   = (WB > HB) ? WB : HB;
	localparam int SW    = (SW0 > SIZE_W) ? SW0 : SIZE_W;

	localparam logic [SW-1:0] MAX_W_S = SW'(MAX_WIDTH);
	localparam logic [SW-1:0] MAX_H_S = SW'(MAX_HEIGHT);
	localparam logic [SW-1:0] MIN_S   = SW'(MIN_SIZE);
	localparam logic [SW-1:0] ONE_S   = SW'(1);
	localparam logic [SW-1:0] RST_W_S = (SW'(SIZE_RESET) > MAX_W_S) ? MAX_W_S : SW'(SIZE_RESET);
	localparam logic [SW-1:0] RST_H_S = (SW'(SIZE_RESET) > MAX_H_S) ? MAX_H_S : SW'(SIZE_RESET);

	// Registers.
	state_t               state_q, state_d;
	logic [SIZE_W-1:0]    width_q, height_q;
	logic [OP_W-1:0]      op_q;
	dir_t                 dir_q;
	logic [COORD_W-1:0]   cx_q, cy_q;
	logic [XW-1:0]        ox_q, nx_q, sx_q;
	logic [YW-1:0]        oy_q, ny_q, sy_q;
	logic [SW-1:0]        run_w_q, run_h_q;
	logic                 reply_q;
	logic [CELL_W-1:0]    rd_q;
	logic                 res_ok_q;
	logic [CELL_W-1:0]    res_val_q;
	logic                 rsp_valid_q;
	logic                 accepted_q;
	logic [COORD_W-1:0]   origin_col_q, origin_row_q;
	logic [CELL_W-1:0]    cell_value_q;

	// Cell memory.
	logic [CELL_W-1:0]    mem [DEPTH];

	// Combinational signals.
	logic [SW-1:0]        used_w, used_h;
	logic                 move_ok;
	logic [XW-1:0]        nx_c;
	logic [YW-1:0]        ny_c;
	logic                 rd_in_range;
	logic                 sweep_last_x, sweep_last_y;
	logic [CELL_W-1:0]    sweep_val;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_addr;
	logic [CELL_W-1:0]    mem_wdata;
	logic                 rsp_free;

	// Grid size in use: the registers clamped to the legal range.
	always_comb begin
		if (SW'(width_q) < MIN_S) begin
			used_w = MIN_S;
		end else if (SW'(width_q) > MAX_W_S) begin
			used_w = MAX_W_S;
		end else begin
			used_w = SW'(width_q);
		end
		if (SW'(height_q) < MIN_S) begin
			used_h = MIN_S;
		end else if (SW'(height_q) > MAX_H_S) begin
			used_h = MAX_H_S;
		end else begin
			used_h = SW'(height_q);
		end
	end

	// Move legality and the new origin position.
	always_comb begin
		move_ok = 1'b0;
		nx_c    = ox_q;
		ny_c    = oy_q;
		unique case (dir_q)
			DIR_RIGHT: begin
				move_ok = SW'(ox_q) < (used_w - ONE_S);
				nx_c    = ox_q + XW'(1);
			end
			DIR_DOWN: begin
				move_ok = SW'(oy_q) < (used_h - ONE_S);
				ny_c    = oy_q + YW'(1);
			end
			DIR_LEFT: begin
				move_ok = (ox_q != '0);
				nx_c    = ox_q - XW'(1);
			end
			DIR_UP: begin
				move_ok = (oy_q != '0);
				ny_c    = oy_q - YW'(1);
			end
			default: begin
				move_ok = 1'b0;
			end
		endcase
	end

	// Read bounds and the start pattern for the sweep.
	assign rd_in_range  = (SW'(cx_q) < used_w) && (SW'(cy_q) < used_h);
	assign sweep_last_x = (SW'(sx_q) == (run_w_q - ONE_S));
	assign sweep_last_y = (SW'(sy_q) == (run_h_q - ONE_S));

	always_comb begin
		if (!sweep_last_x) begin
			sweep_val = CELL_RIGHT;
		end else if (sweep_last_y) begin
			sweep_val = CELL_ORIGIN;
		end else begin
			sweep_val = CELL_DOWN;
		end
	end

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (op_q)
					OP_INIT:  state_d = ST_SWEEP;
					OP_SHIFT: state_d = move_ok ? ST_SHIFT2 : ST_RESP;
					OP_READ:  state_d = rd_in_range ? ST_READW : ST_RESP;
					default:  state_d = ST_RESP;
				endcase
			end
			ST_SWEEP: begin
				if (sweep_last_x && sweep_last_y) begin
					state_d = reply_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_SHIFT2: state_d = ST_RESP;
			ST_READW:  state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control and request stall.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = {oy_q, ox_q};
		mem_wdata = CELL_ORIGIN;
		req_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_EXEC: begin
				if (op_q == OP_SHIFT && move_ok) begin
					mem_we    = 1'b1;
					mem_addr  = {oy_q, ox_q};
					mem_wdata = CELL_W'(dir_q);
				end else if (op_q == OP_READ && rd_in_range) begin
					mem_re   = 1'b1;
					mem_addr = {YW'(cy_q), XW'(cx_q)};
				end
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_addr  = {sy_q, sx_q};
				mem_wdata = sweep_val;
			end
			ST_SHIFT2: begin
				mem_we    = 1'b1;
				mem_addr  = {ny_q, nx_q};
				mem_wdata = CELL_ORIGIN;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Single-port cell memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == CFG_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// Sequencer control: state, sweep counters, origin and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sx_q        <= '0;
			sy_q        <= '0;
			run_w_q     <= RST_W_S;
			run_h_q     <= RST_H_S;
			reply_q     <= 1'b0;
			ox_q        <= XW'(RST_W_S - ONE_S);
			oy_q        <= YW'(RST_H_S - ONE_S);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result fills the output register; a taken one empties it.
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EXEC: begin
					if (op_q == OP_INIT) begin
						sx_q    <= '0;
						sy_q    <= '0;
						run_w_q <= used_w;
						run_h_q <= used_h;
						reply_q <= 1'b1;
					end
				end
				ST_SWEEP: begin
					if (sweep_last_x) begin
						sx_q <= '0;
						sy_q <= sy_q + YW'(1);
						if (sweep_last_y) begin
							ox_q <= XW'(run_w_q - ONE_S);
							oy_q <= YW'(run_h_q - ONE_S);
						end
					end else begin
						sx_q <= sx_q + XW'(1);
					end
				end
				ST_SHIFT2: begin
					ox_q <= nx_q;
					oy_q <= ny_q;
				end
				default: begin
					reply_q <= reply_q;
				end
			endcase
		end
	end

	// Request capture and result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			op_q  <= operation;
			dir_q <= dir_t'(direction);
			cx_q  <= cell_x;
			cy_q  <= cell_y;
		end
		if (state_q == ST_EXEC) begin
			nx_q      <= nx_c;
			ny_q      <= ny_c;
			res_val_q <= CELL_RIGHT;
			unique case (op_q)
				OP_INIT:  res_ok_q <= 1'b1;
				OP_SHIFT: res_ok_q <= move_ok;
				OP_READ:  res_ok_q <= rd_in_range;
				default:  res_ok_q <= 1'b0;
			endcase
		end
		if (state_q == ST_READW) begin
			res_val_q <= rd_q;
		end
		if (state_q == ST_RESP && rsp_free) begin
			accepted_q   <= res_ok_q;
			origin_col_q <= COORD_W'(ox_q);
			origin_row_q <= COORD_W'(oy_q);
			cell_value_q <= res_val_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign accepted   = accepted_q;
	assign origin_col = origin_col_q;
	assign origin_row = origin_row_q;
	assign cell_value = cell_value_q;

	// Checks on the sequencer.
	`OSMG_ASSERT_NEXT(a_req_starts_exec, req_valid && !req_stall, state_q == ST_EXEC, "accepted request did not start execution")
	`OSMG_ASSERT_NOW(a_readw_after_read, state_q == ST_READW, $past(mem_re), "read wait without a memory read")
	`OSMG_ASSERT_NOW(a_shift2_after_exec, state_q == ST_SHIFT2, $past(state_q) == ST_EXEC, "second shift write out of sequence")
	`OSMG_ASSERT_NEXT(a_rsp_held_back, state_q == ST_RESP && rsp_valid && rsp_stall, state_q == ST_RESP && rsp_valid, "result overwrote a stalled response")

endmodule

@@ verif/origin_shift_maze_grid_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for origin_shift_maze_grid_top: directed and random requests,
// checked against a grid model kept here. Depends on osmg_pkg and the RTL under hdl.

module origin_shift_maze_grid_top_test;
	import osmg_pkg::*;

	localparam int GRID_MAX      = MAX_WIDTH_DEF;
	localparam int STALL_LIMIT   = 20000;
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 250;
	localparam int TAIL_CYCLES   = 20;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [DIR_W-1:0]   dir;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} maze_request_t;

	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [CELL_W-1:0]  value;
	} maze_answer_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
	logic [SIZE_W-1:0]    cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [OP_W-1:0]      operation = '0;
	logic [DIR_W-1:0]     direction = '0;
	logic [COORD_W-1:0]   cell_x = '0;
	logic [COORD_W-1:0]   cell_y = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic                 accepted;
	logic [COORD_W-1:0]   origin_col;
	logic [COORD_W-1:0]   origin_row;
	logic [CELL_W-1:0]    cell_value;

	origin_shift_maze_grid_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.direction  (direction),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.accepted   (accepted),
		.origin_col (origin_col),
		.origin_row (origin_row),
		.cell_value (cell_value)
	);

	// Grid model state.
	logic [CELL_W-1:0] maze_cells [GRID_MAX][GRID_MAX];
	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	int                org_x;
	int                org_y;

	maze_request_t requests_pending [$];
	maze_answer_t  answers_due [$];
	int            send_idle_pct = 31;
	int            recv_idle_pct = 48;
	int            errors = 0;
	int            results_seen = 0;
	int            hold_left = 0;
	bit            hold_done = 1'b0;
	bit            req_done = 1'b0;
	int            quiet_cycles = 0;

	// A size register below the minimum acts as the minimum, above the capacity as the capacity.
	function automatic int eff_size(logic [SIZE_W-1:0] v);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > GRID_MAX)
			return GRID_MAX;
		return int'(v);
	endfunction

	// Starting maze: all right, last column down, bottom-right corner is the origin.
	function automatic void build_maze();
		int w;
		int h;
		w = eff_size(width_reg);
		h = eff_size(height_reg);
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				if (x != w - 1)
					maze_cells[y][x] = CELL_RIGHT;
				else if (y == h - 1)
					maze_cells[y][x] = CELL_ORIGIN;
				else
					maze_cells[y][x] = CELL_DOWN;
			end
		end
		org_x = w - 1;
		org_y = h - 1;
	endfunction

	// Applies one request to the grid model and returns the answer it produces.
	function automatic maze_answer_t maze_apply(maze_request_t rq);
		maze_answer_t a;
		int w;
		int h;
		int nx;
		int ny;
		bit moved;
		w = eff_size(width_reg);
		h = eff_size(height_reg);
		a.ok = 1'b0;
		a.value = CELL_RIGHT;
		case (rq.op)
			OP_INIT: begin
				build_maze();
				a.ok = 1'b1;
			end
			OP_SHIFT: begin
				nx = org_x;
				ny = org_y;
				moved = 1'b1;
				// Right and down test against the far edge, so an origin left outside a
				// shrunk grid cannot move further out; left and up only stop at zero.
				case (rq.dir)
					DIR_RIGHT: if (org_x >= w - 1) moved = 1'b0; else nx++;
					DIR_DOWN:  if (org_y >= h - 1) moved = 1'b0; else ny++;
					DIR_LEFT:  if (org_x == 0) moved = 1'b0; else nx--;
					default:   if (org_y == 0) moved = 1'b0; else ny--;
				endcase
				if (moved) begin
					maze_cells[org_y][org_x] = {1'b0, rq.dir};
					maze_cells[ny][nx] = CELL_ORIGIN;
					org_x = nx;
					org_y = ny;
				end
				a.ok = moved;
			end
			OP_READ: begin
				if (rq.x < w && rq.y < h) begin
					a.value = maze_cells[rq.y][rq.x];
					a.ok = 1'b1;
				end
			end
			default: ;
		endcase
		a.col = org_x[COORD_W-1:0];
		a.row = org_y[COORD_W-1:0];
		return a;
	endfunction

	function automatic void queue_request(logic [OP_W-1:0] op, logic [DIR_W-1:0] dir,
		logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		maze_request_t rq;
		rq.op = op;
		rq.dir = dir;
		rq.x = x;
		rq.y = y;
		requests_pending.push_back(rq);
	endfunction

	// Random requests: mostly a random walk of the origin and reads inside the grid,
	// with some initializes, reads anywhere and the unused operation code.
	function automatic void queue_random(int count);
		int w;
		int h;
		int pick;
		w = eff_size(width_reg);
		h = eff_size(height_reg);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				queue_request(OP_SHIFT, DIR_W'($urandom_range(0, 3)),
					COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)));
			else if (pick < 85)
				queue_request(OP_READ, DIR_W'($urandom_range(0, 3)),
					COORD_W'($urandom_range(0, w - 1)), COORD_W'($urandom_range(0, h - 1)));
			else if (pick < 90)
				queue_request(OP_READ, DIR_W'($urandom_range(0, 3)),
					COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)));
			else if (pick < 95)
				queue_request(OP_INIT, DIR_W'($urandom_range(0, 3)),
					COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)));
			else
				queue_request(OP_UNUSED, DIR_W'($urandom_range(0, 3)),
					COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)));
		end
	endfunction

	// Waits until every queued request is taken and every answer has come back.
	task automatic drain();
		while (requests_pending.size() != 0 || req_valid || answers_due.size() != 0)
			@(posedge clk);
	endtask

	// One register write; the model takes the new value when the write lands.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		if (idx == CFG_WIDTH)
			width_reg = data;
		else
			height_reg = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Model reset: every cell set to right, then the start maze at 64 x 64 as the block lays it down.
	initial begin
		for (int y = 0; y < GRID_MAX; y++)
			for (int x = 0; x < GRID_MAX; x++)
				maze_cells[y][x] = CELL_RIGHT;
		width_reg = SIZE_RESET;
		height_reg = SIZE_RESET;
		build_maze();
	end

	// Sequence of phases.
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset size.
		queue_request(OP_READ, DIR_RIGHT, 6'd63, 6'd63);
		queue_request(OP_READ, DIR_RIGHT, 6'd0, 6'd0);
		queue_request(OP_READ, DIR_RIGHT, 6'd63, 6'd0);
		queue_request(OP_READ, DIR_RIGHT, 6'd62, 6'd63);
		queue_request(OP_SHIFT, DIR_RIGHT, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_DOWN, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_LEFT, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_UP, 6'd0, 6'd0);
		queue_request(OP_READ, DIR_UP, 6'd63, 6'd63);
		queue_request(OP_READ, DIR_RIGHT, 6'd62, 6'd62);
		queue_request(OP_UNUSED, DIR_UP, 6'd63, 6'd63);
		queue_request(OP_SHIFT, DIR_RIGHT, 6'd63, 6'd63);
		queue_request(OP_INIT, DIR_RIGHT, 6'd0, 6'd0);
		drain();

		// Shrink to the minimum below range; the origin stays outside the grid.
		write_register(CFG_WIDTH, 7'd0);
		write_register(CFG_HEIGHT, 7'd1);
		queue_request(OP_SHIFT, DIR_RIGHT, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_DOWN, 6'd0, 6'd0);
		queue_request(OP_READ, DIR_RIGHT, 6'd2, 6'd0);
		queue_request(OP_READ, DIR_RIGHT, 6'd0, 6'd2);
		queue_request(OP_READ, DIR_RIGHT, 6'd1, 6'd1);
		queue_request(OP_SHIFT, DIR_LEFT, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_UP, 6'd0, 6'd0);
		queue_request(OP_INIT, DIR_RIGHT, 6'd0, 6'd0);
		queue_request(OP_READ, DIR_RIGHT, 6'd1, 6'd0);
		queue_request(OP_READ, DIR_RIGHT, 6'd1, 6'd1);
		queue_request(OP_SHIFT, DIR_LEFT, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_LEFT, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_UP, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_UP, 6'd0, 6'd0);
		drain();

		// Phase with sender idling less than the receiver; the long receiver
		// hold-off falls in here.
		write_register(CFG_WIDTH, 7'd5);
		write_register(CFG_HEIGHT, 7'd3);
		queue_request(OP_INIT, DIR_RIGHT, 6'd0, 6'd0);
		queue_random(64);
		// Sender pauses until the block has answered everything.
		drain();
		queue_random(65);
		drain();

		// Roles swapped; width above capacity and height at the minimum.
		send_idle_pct = 48;
		recv_idle_pct = 31;
		write_register(CFG_WIDTH, 7'd127);
		write_register(CFG_HEIGHT, 7'd2);
		queue_request(OP_INIT, DIR_RIGHT, 6'd0, 6'd0);
		queue_random(119);
		drain();

		// A few requests on the full 64 x 64 grid.
		write_register(CFG_WIDTH, 7'd64);
		write_register(CFG_HEIGHT, 7'd64);
		queue_request(OP_INIT, DIR_RIGHT, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_LEFT, 6'd0, 6'd0);
		queue_request(OP_SHIFT, DIR_UP, 6'd0, 6'd0);
		queue_request(OP_READ, DIR_RIGHT, 6'd63, 6'd63);
		queue_random(6);
		drain();

		// No idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(CFG_WIDTH, 7'd2);
		write_register(CFG_HEIGHT, 7'd9);
		queue_request(OP_INIT, DIR_RIGHT, 6'd0, 6'd0);
		queue_random(129);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("origin_shift_maze_grid_top_test: clean");
		else
			$display("origin_shift_maze_grid_top_test: errors");
		$finish;
	end

	// Request capture: a request taken at this edge goes through the model.
	always @(posedge clk) begin
		maze_request_t rq;
		req_done <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			rq.op = operation;
			rq.dir = direction;
			rq.x = cell_x;
			rq.y = cell_y;
			answers_due.push_back(maze_apply(rq));
		end
	end

	// Request driver: a held request stays put until taken.
	always @(negedge clk) begin
		maze_request_t rq;
		if (arst_n && (!req_valid || req_done)) begin
			if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				rq = requests_pending.pop_front();
				req_valid <= 1'b1;
				operation <= rq.op;
				direction <= rq.dir;
				cell_x <= rq.x;
				cell_y <= rq.y;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each result with the oldest expected answer.
	always @(posedge clk) begin
		maze_answer_t a;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (answers_due.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				a = answers_due.pop_front();
				if (accepted !== a.ok) begin
					$error("accepted: expected %0d, got %0d", a.ok, accepted);
					errors++;
				end
				if (origin_col !== a.col) begin
					$error("origin_col: expected %0d, got %0d", a.col, origin_col);
					errors++;
				end
				if (origin_row !== a.row) begin
					$error("origin_row: expected %0d, got %0d", a.row, origin_row);
					errors++;
				end
				if (cell_value !== a.value) begin
					$error("cell_value: expected %0d, got %0d", a.value, cell_value);
					errors++;
				end
			end
		end
	end

	// Result stall: random, plus one long hold-off once enough results have come.
	always @(negedge clk) begin
		if (!hold_done && results_seen >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Watchdog on cycles in which no channel moves anything.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("origin_shift_maze_grid_top_test: errors");
			$finish;
		end
	end

endmodule
